// ===== rtl/slist_pkg.sv =====
// Shared constants, request codes and sequencer state type for the sequential list engine.
package slist_pkg;

  localparam int CAPACITY = 128;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int WORD_W   = 32;
  localparam int LEN_W    = 8;
  localparam int POS_W    = 8;
  localparam int KIND_W   = 3;

  localparam logic [KIND_W-1:0] KIND_APPEND = 3'd0;
  localparam logic [KIND_W-1:0] KIND_INSERT = 3'd1;
  localparam logic [KIND_W-1:0] KIND_READ   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_FIND   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DELETE = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } seq_state_t;

endpackage

// ===== rtl/slist_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module slist_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/sequential_list_engine.sv =====
// Top level of the sequential list engine: request sequencer around the list memory.
// Append and failed requests go straight to the done state; read, find, delete and insert
// first walk the memory in the scan state, and a find stops at its first match.
// One transaction at a time: in_stall is high outside the idle state, and the single
// memory read port walks one entry per cycle during the scan.
// Reset clears the length and the sequencer; the store is not cleared and needs no sweep.
module sequential_list_engine (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [slist_pkg::KIND_W-1:0]      kind,
  input  logic [slist_pkg::POS_W-1:0]       position,
  input  logic signed [slist_pkg::WORD_W-1:0] value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              ok,
  output logic signed [slist_pkg::WORD_W-1:0] word_out,
  output logic [slist_pkg::POS_W-1:0]       found_position,
  output logic [slist_pkg::LEN_W-1:0]       length_now
);
  import slist_pkg::*;

  seq_state_t state, state_next;

  logic [LEN_W-1:0]         len;
  logic [KIND_W-1:0]        req_kind;
  logic signed [WORD_W-1:0] req_val;
  logic [ADDR_W-1:0]        ptr;
  logic [ADDR_W-1:0]        end_ptr;
  logic [ADDR_W-1:0]        lo;
  logic [ADDR_W-1:0]        daddr;
  logic                     rd_active;
  logic                     pend;
  logic                     res_ok;
  logic [WORD_W-1:0]        res_word;
  logic [POS_W-1:0]         res_found;

  logic                     accept;
  logic                     pos_ok;
  logic                     not_full;
  logic                     match;
  logic                     scan_end;
  logic                     out_load;

  logic                     mem_we;
  logic [ADDR_W-1:0]        mem_waddr;
  logic [WORD_W-1:0]        mem_wdata;
  logic [WORD_W-1:0]        rd_data;

  slist_ram #(
    .WIDTH (WORD_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (rd_active),
    .raddr (ptr),
    .rdata (rd_data)
  );

  assign accept   = in_valid && !in_stall;
  assign pos_ok   = (position != '0) && (position <= len);
  assign not_full = len < LEN_W'(CAPACITY);
  assign match    = pend && (req_kind == KIND_FIND) && (rd_data == req_val);
  assign scan_end = !rd_active && !pend;
  assign out_load = !out_valid || !out_stall;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_DONE;
          unique case (kind)
            KIND_INSERT: if (pos_ok && not_full) state_next = ST_SCAN;
            KIND_READ,
            KIND_DELETE: if (pos_ok) state_next = ST_SCAN;
            KIND_FIND:   if (len != '0) state_next = ST_SCAN;
            default:     state_next = ST_DONE;
          endcase
        end
      end
      ST_SCAN: begin
        if (match || scan_end) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Handshake and memory write control.
  always_comb begin
    in_stall  = (state != ST_IDLE);
    mem_we    = 1'b0;
    mem_waddr = daddr;
    mem_wdata = rd_data;
    unique case (state)
      ST_IDLE: begin
        mem_we    = accept && (kind == KIND_APPEND) && not_full;
        mem_waddr = len[ADDR_W-1:0];
        mem_wdata = value;
      end
      ST_SCAN: begin
        if (pend && (req_kind == KIND_INSERT)) begin
          // Shift up: the word read from daddr moves one place towards the end.
          mem_we    = 1'b1;
          mem_waddr = daddr + ADDR_W'(1);
        end else if (pend && (req_kind == KIND_DELETE) && (daddr != lo)) begin
          mem_we    = 1'b1;
          mem_waddr = daddr - ADDR_W'(1);
        end else if (scan_end && (req_kind == KIND_INSERT)) begin
          mem_we    = 1'b1;
          mem_waddr = lo;
          mem_wdata = req_val;
        end
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      len       <= '0;
      rd_active <= 1'b0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;

      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            req_kind  <= kind;
            req_val   <= value;
            res_ok    <= 1'b0;
            res_word  <= '0;
            res_found <= '0;
            lo        <= ADDR_W'(position - POS_W'(1));
            unique case (kind)
              KIND_APPEND: begin
                if (not_full) begin
                  res_ok <= 1'b1;
                  len    <= len + LEN_W'(1);
                end
              end
              KIND_INSERT: begin
                ptr       <= ADDR_W'(len - LEN_W'(1));
                end_ptr   <= ADDR_W'(position - POS_W'(1));
                rd_active <= pos_ok && not_full;
              end
              KIND_READ: begin
                ptr       <= ADDR_W'(position - POS_W'(1));
                end_ptr   <= ADDR_W'(position - POS_W'(1));
                rd_active <= pos_ok;
              end
              KIND_DELETE: begin
                ptr       <= ADDR_W'(position - POS_W'(1));
                end_ptr   <= ADDR_W'(len - LEN_W'(1));
                rd_active <= pos_ok;
              end
              KIND_FIND: begin
                ptr       <= '0;
                end_ptr   <= ADDR_W'(len - LEN_W'(1));
                rd_active <= (len != '0);
              end
              default: rd_active <= 1'b0;
            endcase
          end
        end

        ST_SCAN: begin
          if (rd_active) begin
            pend  <= 1'b1;
            daddr <= ptr;
            if (ptr == end_ptr) begin
              rd_active <= 1'b0;
            end else if (req_kind == KIND_INSERT) begin
              ptr <= ptr - ADDR_W'(1);
            end else begin
              ptr <= ptr + ADDR_W'(1);
            end
          end else begin
            pend <= 1'b0;
          end

          if (pend && (daddr == lo) &&
              ((req_kind == KIND_READ) || (req_kind == KIND_DELETE))) begin
            res_word <= rd_data;
          end

          if (match) begin
            res_ok    <= 1'b1;
            res_found <= POS_W'(daddr) + POS_W'(1);
            rd_active <= 1'b0;
            pend      <= 1'b0;
          end

          if (scan_end) begin
            if (req_kind == KIND_INSERT) begin
              res_ok <= 1'b1;
              len    <= len + LEN_W'(1);
            end else if (req_kind == KIND_DELETE) begin
              res_ok <= 1'b1;
              len    <= len - LEN_W'(1);
            end else if (req_kind == KIND_READ) begin
              res_ok <= 1'b1;
            end
          end
        end

        ST_DONE: begin
          if (out_load) begin
            out_valid      <= 1'b1;
            ok             <= res_ok;
            word_out       <= res_word;
            found_position <= res_found;
            length_now     <= len;
          end
        end

        default: pend <= 1'b0;
      endcase
    end
  end

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    len <= LEN_W'(CAPACITY))
    else $error("list length above capacity");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (mem_we && rd_active) |-> (mem_waddr != ptr))
    else $error("memory written and read at the same entry in one cycle");

  a_pend_in_scan: assert property (@(posedge clk) disable iff (rst)
    (pend || rd_active) |-> (state == ST_SCAN))
    else $error("memory walk active outside the scan state");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_DONE))
    else $error("result register loaded outside the done state");

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the sequential list engine with a mirrored list and reply queue.
`timescale 1ns / 1ps

module tb_top;
  import slist_pkg::*;

  localparam int unsigned TIMEOUT_CYCLES = 1_500_000;
  localparam int unsigned RANDOM_REQUESTS = 1000;
  localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;
  localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;

  typedef struct {
    logic                     ok;
    logic signed [WORD_W-1:0] word;
    logic [POS_W-1:0]         found;
    logic [LEN_W-1:0]         len;
  } list_reply_t;

  // Mirror of the list contents; predicts one reply per accepted request.
  class list_scoreboard;
    logic signed [WORD_W-1:0] entries [CAPACITY];
    int unsigned count;
    list_reply_t pending [$];
    int unsigned failures;

    function new();
      count = 0;
      failures = 0;
    endfunction

    function void note_request(logic [KIND_W-1:0] k, logic [POS_W-1:0] p,
                               logic signed [WORD_W-1:0] v);
      list_reply_t r;
      bit pos_ok;
      int j;
      r.ok = 1'b0;
      r.word = '0;
      r.found = '0;
      pos_ok = (p >= 1) && (p <= count);
      case (k)
        KIND_APPEND: begin
          if (count < CAPACITY) begin
            entries[count] = v;
            count++;
            r.ok = 1'b1;
          end
        end
        KIND_INSERT: begin
          if (pos_ok && count < CAPACITY) begin
            for (j = count; j > p - 1; j--) entries[j] = entries[j-1];
            entries[p-1] = v;
            count++;
            r.ok = 1'b1;
          end
        end
        KIND_READ: begin
          if (pos_ok) begin
            r.word = entries[p-1];
            r.ok = 1'b1;
          end
        end
        KIND_FIND: begin
          for (j = 0; j < count; j++) begin
            if (entries[j] == v) begin
              r.found = POS_W'(j + 1);
              r.ok = 1'b1;
              break;
            end
          end
        end
        KIND_DELETE: begin
          if (pos_ok) begin
            r.word = entries[p-1];
            for (j = p; j < count; j++) entries[j-1] = entries[j];
            count--;
            r.ok = 1'b1;
          end
        end
        default: ;
      endcase
      r.len = LEN_W'(count);
      pending.push_back(r);
    endfunction

    function void compare_field(string name, logic signed [63:0] want,
                                logic signed [63:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        failures++;
      end
    endfunction

    function void check_reply(logic got_ok, logic signed [WORD_W-1:0] got_word,
                              logic [POS_W-1:0] got_found, logic [LEN_W-1:0] got_len);
      list_reply_t r;
      if (pending.size() == 0) begin
        $error("reply transaction arrived with no request outstanding");
        failures++;
        return;
      end
      r = pending.pop_front();
      compare_field("ok", r.ok, got_ok);
      compare_field("word_out", r.word, got_word);
      compare_field("found_position", r.found, got_found);
      compare_field("length_now", r.len, got_len);
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [KIND_W-1:0] kind = '0;
  logic [POS_W-1:0] position = '0;
  logic signed [WORD_W-1:0] value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic ok;
  logic signed [WORD_W-1:0] word_out;
  logic [POS_W-1:0] found_position;
  logic [LEN_W-1:0] length_now;

  list_scoreboard mirror = new();
  int burst_left = 0;
  int stall_span = 0;
  int stall_style = 0;

  sequential_list_engine uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .position(position), .value(value),
    .out_valid(out_valid), .out_stall(out_stall),
    .ok(ok), .word_out(word_out), .found_position(found_position),
    .length_now(length_now)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_CYCLES * 10);
    $display("sequential_list_engine: mismatch");
    $finish;
  end

  // The receiver switches between free running, random stalls and heavy back-pressure.
  always @(negedge clk) begin
    if (stall_span == 0) begin
      stall_style = $urandom_range(0, 2);
      stall_span = $urandom_range(10, 80);
    end
    stall_span--;
    case (stall_style)
      0: out_stall <= 1'b0;
      1: out_stall <= 1'($urandom_range(0, 1));
      default: out_stall <= ($urandom_range(0, 7) != 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      mirror.check_reply(ok, word_out, found_position, length_now);
  end

  task automatic send_request(logic [KIND_W-1:0] k, logic [POS_W-1:0] p,
                              logic signed [WORD_W-1:0] v);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    in_valid <= 1'b1;
    kind <= k;
    position <= p;
    value <= v;
    do @(posedge clk); while (in_stall);
    mirror.note_request(k, p, v);
    burst_left--;
  endtask

  function automatic logic [POS_W-1:0] pick_position();
    int r;
    r = $urandom_range(0, 9);
    if (mirror.count > 0 && r < 7) return POS_W'($urandom_range(1, mirror.count));
    if (r == 7) return '0;
    if (r == 8) return POS_W'(mirror.count + 1);
    return POS_W'($urandom_range(0, 255));
  endfunction

  function automatic logic signed [WORD_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return WORD_MIN;
      1: return WORD_MAX;
      2, 3: return $signed($urandom_range(0, 4)) - 2;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [KIND_W-1:0] k;
    logic [POS_W-1:0] p;
    logic signed [WORD_W-1:0] v;
    int r;
    bit growing;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: failures on an empty list, extreme words, front and mid-list inserts, duplicates.
    send_request(KIND_READ, 1, 0);
    send_request(KIND_DELETE, 1, 0);
    send_request(KIND_INSERT, 1, 3);
    send_request(KIND_FIND, 0, 0);
    send_request(KIND_SPARE_LO, 1, 9);
    send_request(KIND_SPARE_HI, 255, -1);
    send_request(KIND_APPEND, 0, WORD_MAX);
    send_request(KIND_APPEND, 255, WORD_MIN);
    send_request(KIND_APPEND, 0, 0);
    send_request(KIND_APPEND, 0, -1);
    send_request(KIND_INSERT, 1, 7);
    send_request(KIND_INSERT, 5, 7);
    send_request(KIND_INSERT, 7, 11);
    send_request(KIND_READ, 0, 0);
    send_request(KIND_READ, 6, 0);
    send_request(KIND_READ, 255, 0);
    send_request(KIND_FIND, 0, 7);
    send_request(KIND_FIND, 0, WORD_MIN);
    send_request(KIND_DELETE, 6, 0);
    send_request(KIND_DELETE, 1, 0);
    send_request(KIND_DELETE, 0, 0);
    send_request(KIND_FIND, 0, 12345);
    send_request(KIND_DELETE, 255, 0);

    // Random: alternate filling towards capacity and draining back to empty.
    growing = 1'b1;
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (growing && mirror.count == CAPACITY && $urandom_range(0, 3) == 0) growing = 1'b0;
      if (!growing && mirror.count == 0) growing = 1'b1;
      r = $urandom_range(0, 99);
      if (growing)
        k = (r < 45) ? KIND_APPEND : (r < 65) ? KIND_INSERT : (r < 75) ? KIND_READ :
            (r < 85) ? KIND_FIND : (r < 95) ? KIND_DELETE : KIND_SPARE_LO;
      else
        k = (r < 8) ? KIND_APPEND : (r < 12) ? KIND_INSERT : (r < 20) ? KIND_READ :
            (r < 30) ? KIND_FIND : (r < 95) ? KIND_DELETE : KIND_SPARE_LO;
      if (k == KIND_SPARE_LO) k = KIND_W'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
      if (k == KIND_APPEND || k == KIND_FIND) p = POS_W'($urandom_range(0, 255));
      else p = pick_position();
      // Finds mostly look for a word already in the list so that matches are common.
      if (k == KIND_FIND && mirror.count > 0 && $urandom_range(0, 9) < 6)
        v = mirror.entries[$urandom_range(0, mirror.count - 1)];
      else
        v = pick_value();
      send_request(k, p, v);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (mirror.pending.size() != 0) @(posedge clk);
    repeat (CAPACITY + 10) @(posedge clk);
    if (mirror.failures == 0)
      $display("sequential_list_engine: match");
    else
      $display("sequential_list_engine: mismatch");
    $finish;
  end

endmodule
